// File: rtl/slcfc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte step for the frame checker.
// No dependencies; used by slcfc_deframer and sync_length_crc16_frame_checker.
package slcfc_pkg;

	localparam int MAX_PAYLOAD = 76;
	localparam int HDR_BYTES   = 6;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 7;
	localparam int STAT_W = 2;
	localparam int CRC_W  = 16;
	localparam int POS_W  = $clog2(HDR_BYTES + MAX_PAYLOAD + 1);
	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int CFG_IDX_W = 1;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h5A;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hA5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

	// Header positions within a frame
	localparam logic [POS_W-1:0] POS_SYNC0  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC1  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(3);
	localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(5);

	typedef enum logic [STAT_W-1:0] {
		STAT_CRC_OK  = 2'd0,
		STAT_CRC_BAD = 2'd1,
		STAT_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              frame_start;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic [IDX_W-1:0]  byte_index;
		logic              is_last;
		status_t           status;
	} result_t;

	// CRC-16, polynomial 0x1021, MSB first, one byte per call
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/slcfc_deframer.sv
`timescale 1ns / 1ps
// Frame state, sync registers and the one-byte step of the deframer.
// Depends on slcfc_pkg.
module slcfc_deframer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [slcfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slcfc_pkg::BYTE_W-1:0]       cfg_data,
	input  logic                               step_en,
	input  slcfc_pkg::item_t                   item,
	output logic                               res_valid,
	output slcfc_pkg::result_t                 res
);

	localparam int POS_W = slcfc_pkg::POS_W;
	localparam int LEN_W = slcfc_pkg::LEN_W;

	logic [slcfc_pkg::BYTE_W-1:0] sync_first_q, sync_second_q;
	logic                         active_q;
	logic [POS_W-1:0]             pos_q;
	logic [slcfc_pkg::CRC_W-1:0]  crc_q;
	logic [slcfc_pkg::CRC_W-1:0]  chk_q;
	logic [slcfc_pkg::BYTE_W-1:0] len_lo_q;
	logic [LEN_W-1:0]             len_q;

	logic                         act_n;
	logic [POS_W-1:0]             pos_cur, pos_n;
	logic [slcfc_pkg::CRC_W-1:0]  crc_cur, crc_n, crc_b, chk_n, chk_full;
	logic [slcfc_pkg::BYTE_W-1:0] len_lo_n, b;
	logic [LEN_W-1:0]             len_n;
	logic [15:0]                  len_full;
	logic [POS_W-1:0]             pay_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= slcfc_pkg::SYNC_FIRST_RST;
			sync_second_q <= slcfc_pkg::SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slcfc_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				slcfc_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign b        = item.rx_byte;
	assign pos_cur  = item.frame_start ? '0 : pos_q;
	assign crc_cur  = item.frame_start ? '0 : crc_q;
	assign crc_b    = slcfc_pkg::crc16_byte(crc_cur, b);
	assign len_full = {b, len_lo_q};
	assign chk_full = {b, chk_q[7:0]};
	assign pay_idx  = pos_cur - POS_W'(slcfc_pkg::HDR_BYTES);

	always_comb begin
		act_n     = item.frame_start | active_q;
		pos_n     = pos_cur;
		crc_n     = crc_cur;
		chk_n     = chk_q;
		len_lo_n  = len_lo_q;
		len_n     = len_q;
		res_valid = 1'b0;
		res       = '0;
		if (act_n) begin
			case (pos_cur)
				slcfc_pkg::POS_SYNC0, slcfc_pkg::POS_SYNC1: begin
					if (b != ((pos_cur == slcfc_pkg::POS_SYNC0) ? sync_first_q
							: sync_second_q)) begin
						act_n = 1'b0;
					end else begin
						crc_n = crc_b;
						pos_n = pos_cur + POS_W'(1);
					end
				end
				slcfc_pkg::POS_LEN_LO: begin
					len_lo_n = b;
					crc_n    = crc_b;
					pos_n    = pos_cur + POS_W'(1);
				end
				slcfc_pkg::POS_LEN_HI: begin
					crc_n = crc_b;
					pos_n = pos_cur + POS_W'(1);
					if (len_full > 16'(slcfc_pkg::MAX_PAYLOAD)) begin
						act_n          = 1'b0;
						res_valid      = 1'b1;
						res.is_last    = 1'b1;
						res.status     = slcfc_pkg::STAT_TOO_LONG;
					end else begin
						len_n = len_full[LEN_W-1:0];
					end
				end
				slcfc_pkg::POS_CHK_LO: begin
					chk_n = {chk_q[15:8], b};
					pos_n = pos_cur + POS_W'(1);
				end
				slcfc_pkg::POS_CHK_HI: begin
					chk_n = chk_full;
					pos_n = pos_cur + POS_W'(1);
					if (len_q == '0) begin
						act_n       = 1'b0;
						res_valid   = 1'b1;
						res.is_last = 1'b1;
						res.status  = (crc_cur == chk_full) ? slcfc_pkg::STAT_CRC_OK
							: slcfc_pkg::STAT_CRC_BAD;
					end
				end
				default: begin
					// payload byte: pass through and fold into the CRC
					crc_n            = crc_b;
					pos_n            = pos_cur + POS_W'(1);
					res_valid        = 1'b1;
					res.payload_byte = b;
					res.byte_index   = slcfc_pkg::IDX_W'(pay_idx);
					if ((POS_W + 1)'(pay_idx) + (POS_W + 1)'(1)
							>= (POS_W + 1)'(len_q)) begin
						act_n       = 1'b0;
						res.is_last = 1'b1;
						res.status  = (crc_b == chk_q) ? slcfc_pkg::STAT_CRC_OK
							: slcfc_pkg::STAT_CRC_BAD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
			crc_q    <= '0;
			chk_q    <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
		end else if (step_en) begin
			active_q <= act_n;
			pos_q    <= pos_n;
			crc_q    <= crc_n;
			chk_q    <= chk_n;
			len_lo_q <= len_lo_n;
			len_q    <= len_n;
		end
	end

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && res.is_last |=> !active_q)
		else $error("frame still active after its final result");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> pos_q <= POS_W'(slcfc_pkg::HDR_BYTES + slcfc_pkg::MAX_PAYLOAD - 1))
		else $error("position past the payload bound");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && (pos_q > slcfc_pkg::POS_LEN_HI)
		|-> len_q <= LEN_W'(slcfc_pkg::MAX_PAYLOAD))
		else $error("accepted length exceeds the payload bound");

	a_payload_only_when_active: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && !res.is_last |=> active_q)
		else $error("frame ended on a non-final result");

endmodule

// File: rtl/sync_length_crc16_frame_checker.sv
`timescale 1ns / 1ps
// Top level: input register, deframer step and output register of the checker.
// Depends on slcfc_pkg and slcfc_deframer.
// Each transferred byte is held in the input register, stepped (CRC-16 over one
// byte plus header decode), and any result is loaded into the output register.
// Throughput: one input byte per cycle while the output register is empty or
// drained, set by the single byte step between the input and output registers.
// Reset: arst_n clears all frame state and valid flags at once; sync registers
// return to 0x5A and 0xA5. No clearing pass is needed.
module sync_length_crc16_frame_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [slcfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slcfc_pkg::BYTE_W-1:0]       cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [slcfc_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                               frame_start,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [slcfc_pkg::BYTE_W-1:0]       payload_byte,
	output logic [slcfc_pkg::IDX_W-1:0]        byte_index,
	output logic                               is_last,
	output logic [slcfc_pkg::STAT_W-1:0]       status
);

	logic                 valid_s1;
	slcfc_pkg::item_t     item_s1;
	logic                 valid_s2;
	slcfc_pkg::result_t   res_s2;

	logic                 advance;
	logic                 res_valid;
	slcfc_pkg::result_t   res;

	// Advance the held byte whenever the output register is empty or being drained;
	// bytes that produce no result still advance and only update frame state.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register: hold one transferred byte until the step consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.rx_byte     <= rx_byte;
			item_s1.frame_start <= frame_start;
		end
	end

	slcfc_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step_en   (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: load a result on advance, drop valid once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign payload_byte = res_s2.payload_byte;
	assign byte_index   = res_s2.byte_index;
	assign is_last      = res_s2.is_last;
	assign status       = res_s2.status;

endmodule

// File: tb/sync_length_crc16_frame_checker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sync_length_crc16_frame_checker: a directed stimulus
// table, then random frames under several sync settings, checked by a byte-level deframer.
// Depends on slcfc_pkg and the checker RTL only.
module sync_length_crc16_frame_checker_tb;

	import slcfc_pkg::*;

	localparam int ITEMS_PER_PHASE = 160;
	localparam int NUM_PHASES      = 5;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int LONG_HOLD       = 120;
	localparam int SETTLE_CYCLES   = 4;

	// One stimulus row: the byte, its start marker and, where it is obvious,
	// the result typed in by hand.
	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		logic              start;
		logic              typed;
		result_t           res;
	} stim_row_t;

	localparam result_t NO_RES       = '0;
	localparam result_t RES_TOO_LONG = {8'h00, 7'd0, 1'b1, STAT_TOO_LONG};
	localparam result_t RES_FIRST_00 = {8'h00, 7'd0, 1'b0, STAT_CRC_OK};

	// Directed part, all under the reset sync values 0x5A / 0xA5
	stim_row_t dir_tbl [25] = '{
		{8'hFF, 1'b0, 1'b0, NO_RES},       // stray byte with no frame open: ignored
		{8'h00, 1'b1, 1'b0, NO_RES},       // bad first sync byte
		{8'h5A, 1'b1, 1'b0, NO_RES},
		{8'h5B, 1'b0, 1'b0, NO_RES},       // bad second sync byte
		{8'h5A, 1'b1, 1'b0, NO_RES},
		{8'hA5, 1'b0, 1'b0, NO_RES},
		{8'hFF, 1'b0, 1'b0, NO_RES},
		{8'hFF, 1'b0, 1'b1, RES_TOO_LONG}, // length 0xFFFF: status only
		{8'h5A, 1'b1, 1'b0, NO_RES},
		{8'hA5, 1'b0, 1'b0, NO_RES},
		{8'h00, 1'b0, 1'b0, NO_RES},
		{8'h00, 1'b0, 1'b0, NO_RES},
		{8'h00, 1'b0, 1'b0, NO_RES},
		{8'h00, 1'b0, 1'b0, NO_RES},       // empty payload: status from header CRC
		{8'h5A, 1'b1, 1'b0, NO_RES},
		{8'hA5, 1'b0, 1'b0, NO_RES},       // cut short by the next start
		{8'h5A, 1'b1, 1'b0, NO_RES},
		{8'hA5, 1'b0, 1'b0, NO_RES},
		{8'h02, 1'b0, 1'b0, NO_RES},
		{8'h00, 1'b0, 1'b0, NO_RES},
		{8'h34, 1'b0, 1'b0, NO_RES},
		{8'h12, 1'b0, 1'b0, NO_RES},
		{8'h00, 1'b0, 1'b1, RES_FIRST_00}, // first payload byte passes through
		{8'hFF, 1'b0, 1'b0, NO_RES},       // last payload byte carries the CRC verdict
		{8'h80, 1'b0, 1'b0, NO_RES}        // trailing byte after the frame: ignored
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 frame_start = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    payload_byte;
	logic [IDX_W-1:0]     byte_index;
	logic                 is_last;
	logic [STAT_W-1:0]    status;

	sync_length_crc16_frame_checker uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.payload_byte(payload_byte),
		.byte_index  (byte_index),
		.is_last     (is_last),
		.status      (status)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Deframer state mirrored by the testbench
	logic [BYTE_W-1:0] sync_a = SYNC_FIRST_RST;
	logic [BYTE_W-1:0] sync_b = SYNC_SECOND_RST;
	int                fr_pos = 0;
	bit                fr_active = 1'b0;
	logic [CRC_W-1:0]  fr_crc = '0;
	logic [CRC_W-1:0]  fr_chk = '0;
	logic [15:0]       fr_len = '0;

	stim_row_t stim_q [$];
	result_t   expected_q [$];
	int        mismatches = 0;
	int        cycles = 0;

	// Sender pacing
	stim_row_t cur_row = '0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        in_xfers = 0;
	bit        drain_pause = 1'b0;

	// Receiver pacing
	logic [15:0] ready_pat = 16'hFFFF;
	logic [3:0]  pat_ph = '0;
	int          hold_left = 0;
	int          out_xfers = 0;
	logic        rx_holding = 1'b0;

	// CRC-16/0x1021, one data bit at a time from the MSB
	function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = c[CRC_W-1] ^ b[i];
			c = c << 1;
			if (fb)
				c = c ^ 16'h1021;
		end
		return c;
	endfunction

	// Advance the deframer by one byte; got is set when the byte yields a result
	task automatic deframe_step(input logic [BYTE_W-1:0] b, input logic st,
		output bit got, output result_t r);
		int idx;
		got = 1'b0;
		r = '0;
		if (st) begin
			fr_active = 1'b1;
			fr_pos = 0;
			fr_crc = '0;
		end
		if (fr_active) begin
			case (fr_pos)
				0, 1: begin
					if (b != (fr_pos == 0 ? sync_a : sync_b)) begin
						fr_active = 1'b0;
					end else begin
						fr_crc = crc16_next(fr_crc, b);
						fr_pos++;
					end
				end
				2: begin
					fr_len = {8'h00, b};
					fr_crc = crc16_next(fr_crc, b);
					fr_pos++;
				end
				3: begin
					fr_len[15:8] = b;
					fr_crc = crc16_next(fr_crc, b);
					fr_pos++;
					if (fr_len > MAX_PAYLOAD) begin
						fr_active = 1'b0;
						got = 1'b1;
						r.is_last = 1'b1;
						r.status = STAT_TOO_LONG;
					end
				end
				4: begin
					fr_chk = {8'h00, b};
					fr_pos++;
				end
				5: begin
					fr_chk[15:8] = b;
					fr_pos++;
					if (fr_len == 0) begin
						fr_active = 1'b0;
						got = 1'b1;
						r.is_last = 1'b1;
						r.status = (fr_crc == fr_chk) ? STAT_CRC_OK : STAT_CRC_BAD;
					end
				end
				default: begin
					idx = fr_pos - HDR_BYTES;
					fr_crc = crc16_next(fr_crc, b);
					fr_pos++;
					got = 1'b1;
					r.payload_byte = b;
					r.byte_index = idx[IDX_W-1:0];
					if (idx + 1 >= fr_len) begin
						fr_active = 1'b0;
						r.is_last = 1'b1;
						r.status = (fr_crc == fr_chk) ? STAT_CRC_OK : STAT_CRC_BAD;
					end
				end
			endcase
		end
	endtask

	function automatic void flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Sender: predict each accepted transfer, then offer the next row in bursts.
	// Every 97 transfers, pause until all pending results are back.
	always @(posedge clk) begin : sender
		bit      got;
		result_t r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				deframe_step(cur_row.rx, cur_row.start, got, r);
				if (cur_row.typed)
					expected_q.push_back(cur_row.res);
				else if (got)
					expected_q.push_back(r);
				in_xfers++;
				if (in_xfers % 97 == 0)
					drain_pause = 1'b1;
			end
			if (drain_pause && expected_q.size() == 0)
				drain_pause = 1'b0;
			if (in_valid && !in_ready) begin
				// hold the current transfer
			end else if (gap_left == 0 && !drain_pause && stim_q.size() != 0) begin
				cur_row = stim_q.pop_front();
				in_valid <= 1'b1;
				rx_byte <= cur_row.rx;
				frame_start <= cur_row.start;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					// no gaps while the receiver is holding off, so the block fills up
					if (rx_holding)
						gap_left = 0;
					else
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
				end
			end else begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end
		end
	end

	// Receiver: stall on a 16-bit ready pattern, renewed each round, and now
	// and then hold off for a long stretch
	always @(posedge clk) begin : receiver
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (out_xfers % 150 == 75)
					hold_left = LONG_HOLD;
				out_xfers++;
			end
			if (pat_ph == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pat = 16'hFFFF;
					1: ready_pat = 16'($urandom);
					2: ready_pat = 16'($urandom) & 16'($urandom);
					default: ready_pat = 16'($urandom) | 16'($urandom);
				endcase
			end
			pat_ph = pat_ph + 4'd1;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
				rx_holding <= 1'b1;
			end else begin
				out_ready <= ready_pat[pat_ph];
				rx_holding <= 1'b0;
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result byte=%02h idx=%0d last=%0b st=%0d",
					payload_byte, byte_index, is_last, status));
			end else begin
				e = expected_q.pop_front();
				if (payload_byte !== e.payload_byte || byte_index !== e.byte_index ||
					is_last !== e.is_last || status !== e.status)
					flag_mismatch($sformatf(
						"exp byte=%02h idx=%0d last=%0b st=%0d, got byte=%02h idx=%0d last=%0b st=%0d",
						e.payload_byte, e.byte_index, e.is_last, e.status,
						payload_byte, byte_index, is_last, status));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("sync_length_crc16_frame_checker: mismatch");
			$finish;
		end
	end

	// Wait until every row is accepted and every result is back, then let the
	// pipeline settle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (stim_q.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : main_seq
		logic [BYTE_W-1:0] s0, s1, b;
		logic [15:0]       flen, crc, chk;
		logic [BYTE_W-1:0] fbytes [$];
		logic [BYTE_W-1:0] pay [$];
		int                kind, cut, n_gen, extra;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_tbl[i])
			stim_q.push_back(dir_tbl[i]);
		wait_drained();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// Phase 0 keeps the reset values; then both extremes, random, reset again
			case (phase)
				0: begin
					s0 = SYNC_FIRST_RST;
					s1 = SYNC_SECOND_RST;
				end
				1: begin
					s0 = 8'h00;
					s1 = 8'hFF;
				end
				2: begin
					s0 = 8'hFF;
					s1 = 8'h00;
				end
				3: begin
					s0 = 8'($urandom);
					s1 = 8'($urandom);
				end
				default: begin
					s0 = SYNC_FIRST_RST;
					s1 = SYNC_SECOND_RST;
				end
			endcase
			if (phase > 0) begin
				cfg_we <= 1'b1;
				cfg_index <= REG_SYNC_FIRST;
				cfg_data <= s0;
				@(posedge clk);
				cfg_index <= REG_SYNC_SECOND;
				cfg_data <= s1;
				@(posedge clk);
				cfg_we <= 1'b0;
				sync_a = s0;
				sync_b = s1;
			end

			n_gen = 0;
			while (n_gen < ITEMS_PER_PHASE) begin
				fbytes.delete();
				pay.delete();
				kind = $urandom_range(0, 99);
				if (kind < 75) begin
					// Well-formed frame (kind < 65) or one cut short
					case ($urandom_range(0, 19))
						0: flen = 0;
						1: flen = MAX_PAYLOAD;
						2: flen = MAX_PAYLOAD - 1;
						3, 4, 5: flen = $urandom_range(1, MAX_PAYLOAD);
						default: flen = $urandom_range(1, 8);
					endcase
					fbytes.push_back(s0);
					fbytes.push_back(s1);
					fbytes.push_back(flen[7:0]);
					fbytes.push_back(flen[15:8]);
					crc = '0;
					foreach (fbytes[i])
						crc = crc16_next(crc, fbytes[i]);
					for (int i = 0; i < flen; i++) begin
						b = 8'($urandom);
						pay.push_back(b);
						crc = crc16_next(crc, b);
					end
					chk = crc;
					if ($urandom_range(0, 4) == 0)
						chk = crc ^ (16'h0001 << $urandom_range(0, 15));
					fbytes.push_back(chk[7:0]);
					fbytes.push_back(chk[15:8]);
					foreach (pay[i])
						fbytes.push_back(pay[i]);
					if (kind < 65) begin
						cut = fbytes.size();
						if ($urandom_range(0, 6) == 0) begin
							extra = $urandom_range(1, 3);
							repeat (extra) fbytes.push_back(8'($urandom));
							cut = fbytes.size();
						end
					end else begin
						cut = $urandom_range(1, fbytes.size() - 1);
					end
				end else if (kind < 83) begin
					// Length above the bound, with up to two trailing bytes
					case ($urandom_range(0, 3))
						0: flen = MAX_PAYLOAD + 1;
						1: flen = 16'hFFFF;
						default: flen = $urandom_range(MAX_PAYLOAD + 2, 65535);
					endcase
					fbytes.push_back(s0);
					fbytes.push_back(s1);
					fbytes.push_back(flen[7:0]);
					fbytes.push_back(flen[15:8]);
					extra = $urandom_range(0, 2);
					repeat (extra) fbytes.push_back(8'($urandom));
					cut = fbytes.size();
				end else if (kind < 91) begin
					// Bad sync on the first or the second byte
					b = 8'($urandom);
					if ($urandom_range(0, 1) == 0) begin
						if (b == s0)
							b = b ^ (8'h01 << $urandom_range(0, 7));
						fbytes.push_back(b);
					end else begin
						if (b == s1)
							b = b ^ (8'h01 << $urandom_range(0, 7));
						fbytes.push_back(s0);
						fbytes.push_back(b);
					end
					extra = $urandom_range(0, 3);
					repeat (extra) fbytes.push_back(8'($urandom));
					cut = fbytes.size();
				end else begin
					cut = 0;
				end

				if (cut > 0) begin
					for (int i = 0; i < cut; i++)
						stim_q.push_back({fbytes[i], (i == 0), 1'b0, NO_RES});
					n_gen += cut;
				end else begin
					// Noise: random bytes, start marker now and then
					extra = $urandom_range(1, 6);
					repeat (extra)
						stim_q.push_back({8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, NO_RES});
					n_gen += extra;
				end
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("sync_length_crc16_frame_checker: match");
		else
			$display("sync_length_crc16_frame_checker: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
rtl/slcfc_pkg.sv
rtl/slcfc_deframer.sv
rtl/sync_length_crc16_frame_checker.sv
tb/sync_length_crc16_frame_checker_tb.sv
